@@ hw/rtl/pdh_pkg.sv @@
// Shared types and constants of the pair distance histogram unit.
package pdh_pkg;

    // Command codes carried in the input side-band field
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [2:0] CFG_BOX_SIZE  = 3'd0;
    localparam logic [2:0] CFG_PERIODIC  = 3'd1;
    localparam logic [2:0] CFG_BIN_SCALE = 3'd2;
    localparam logic [2:0] CFG_BIN_COUNT = 3'd3;
    localparam logic [2:0] CFG_LABELS    = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;
    localparam int CNT_W      = 20;
    localparam int ROOT_W     = 32;
    localparam int TYPE_W     = 2;
    localparam int BINIDX_W   = 8;
    localparam int COLIDX_W   = 3;
    localparam int LABEL_W    = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Register reset values
    localparam logic [22:0] RST_BOX_SIZE  = 23'd4096;
    localparam logic        RST_PERIODIC  = 1'b1;
    localparam logic [23:0] RST_BIN_SCALE = 24'd65536;
    localparam logic [8:0]  RST_BIN_COUNT = 9'd256;
    localparam logic [35:0] RST_LABELS    = 36'd0;

    // Sequencer states of the back end
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_PAIR_RD,
        ST_DIFF,
        ST_SQ,
        ST_SUM,
        ST_ROOT,
        ST_SCALE,
        ST_BIN,
        ST_HRD,
        ST_HWR,
        ST_STORE,
        ST_RD,
        ST_OUT
    } t_state;

endpackage

@@ hw/rtl/pair_distance_histogram_unit.sv @@
// Pair distance histogram: input stream, command queue and pairing engine.
//
// Slave stream carries commands (tuser: add atom, read bin, clear, no-op) with
// positions, atom type, bin and column in tdata. Master stream returns one
// transfer per read command: the bin count and the column total.
// Configuration is a plain write port (enable, index, data), written while idle.
// An add pairs the new atom with every stored atom through one shared datapath
// (memory read, wrap, squares, sum, a bit-serial square root, scale, and a
// read-modify-write of the all-pairs and the type-pair histogram column),
// then stores it; an add that finds the atom store full is dropped.
// A read passes through the RD and OUT states to the result register; a clear
// sweeps the histogram memory and empties the atom store and column totals.
// After reset the same sweep runs and tready stays low until it completes;
// configuration writes are taken meanwhile.
// A two-entry queue sits between the input and the engine, and the result
// sits in an output register: when the receiver stalls, one result waits
// there and the engine holds at the next read until it is taken.
module pair_distance_histogram_unit
    import pdh_pkg::*;
#(
    parameter int MAX_ATOMS   = 1024,
    parameter int MAX_BINS    = 256,
    parameter int MAX_COLUMNS = 8,
    parameter int COORD_BITS  = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // pos_x, pos_y, pos_z, atom_type, bin_index, column, zero fill
    input  logic [((3*COORD_BITS+13+7)/8)*8-1:0] i_s_tdata,
    // command
    input  logic [1:0]              i_s_tuser,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // bin_pairs, column_pairs
    output logic [2*CNT_W-1:0]      o_m_tdata,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IN_W = ((3*COORD_BITS+13+7)/8)*8;

    logic                         q_valid;
    logic                         q_pop;
    logic                         init;
    t_cmd                         q_cmd;
    logic signed [COORD_BITS-1:0] q_x, q_y, q_z;
    logic [TYPE_W-1:0]            q_type;
    logic [BINIDX_W-1:0]          q_bin;
    logic [COLIDX_W-1:0]          q_col;
    logic [CNT_W-1:0]             bin_pairs;
    logic [CNT_W-1:0]             column_pairs;

    pdh_front #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_tuser  (i_s_tuser),
        .i_hold   (init),
        .o_valid  (q_valid),
        .i_pop    (q_pop),
        .o_cmd    (q_cmd),
        .o_x      (q_x),
        .o_y      (q_y),
        .o_z      (q_z),
        .o_type   (q_type),
        .o_bin    (q_bin),
        .o_col    (q_col)
    );

    pdh_back #(
        .MAX_ATOMS   (MAX_ATOMS),
        .MAX_BINS    (MAX_BINS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (q_valid),
        .o_pop          (q_pop),
        .o_init         (init),
        .i_cmd          (q_cmd),
        .i_x            (q_x),
        .i_y            (q_y),
        .i_z            (q_z),
        .i_type         (q_type),
        .i_bin          (q_bin),
        .i_col          (q_col),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_bin_pairs    (bin_pairs),
        .o_column_pairs (column_pairs)
    );

    assign o_m_tdata = {column_pairs, bin_pairs};

endmodule

@@ hw/rtl/pdh_front.sv @@
// Front end: accepts commands, drops no-ops and queues the rest for the back end.
module pdh_front
    import pdh_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int IN_W       = 88
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tvalid,
    output logic                         o_tready,
    input  logic [IN_W-1:0]              i_tdata,
    input  logic [1:0]                   i_tuser,
    input  logic                         i_hold,
    output logic                         o_valid,
    input  logic                         i_pop,
    output t_cmd                         o_cmd,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_z,
    output logic [TYPE_W-1:0]            o_type,
    output logic [BINIDX_W-1:0]          o_bin,
    output logic [COLIDX_W-1:0]          o_col
);

    localparam int C  = COORD_BITS;
    localparam int EW = 3*C + 13;

    logic [EW-1:0] r_ent [2];
    t_cmd          r_cmd [2];
    logic [1:0]    r_fill;
    logic          r_wp;
    logic          r_rp;
    logic          push;
    logic          pop;
    t_cmd          in_cmd;

    assign in_cmd   = t_cmd'(i_tuser);
    assign o_tready = (r_fill != 2'd2) && !i_hold;
    // no-op commands are taken and dropped here
    assign push     = i_tvalid && o_tready && (in_cmd != CMD_NOP);
    assign o_valid  = (r_fill != 2'd0);
    assign pop      = i_pop && o_valid;

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_fill <= r_fill + 2'(push) - 2'(pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_tdata[EW-1:0];
            r_cmd[r_wp] <= in_cmd;
        end
    end

    assign o_cmd  = r_cmd[r_rp];
    assign o_x    = r_ent[r_rp][C-1:0];
    assign o_y    = r_ent[r_rp][2*C-1:C];
    assign o_z    = r_ent[r_rp][3*C-1:2*C];
    assign o_type = r_ent[r_rp][3*C+1:3*C];
    assign o_bin  = r_ent[r_rp][3*C+9:3*C+2];
    assign o_col  = r_ent[r_rp][3*C+12:3*C+10];

endmodule

@@ hw/rtl/pdh_back.sv @@
// Back end: atom store, pair distance datapath, histogram memory and result register.
module pdh_back
    import pdh_pkg::*;
#(
    parameter int MAX_ATOMS   = 1024,
    parameter int MAX_BINS    = 256,
    parameter int MAX_COLUMNS = 8,
    parameter int COORD_BITS  = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_pop,
    output logic                         o_init,
    input  t_cmd                         i_cmd,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_z,
    input  logic [TYPE_W-1:0]            i_type,
    input  logic [BINIDX_W-1:0]          i_bin,
    input  logic [COLIDX_W-1:0]          i_col,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [CNT_W-1:0]             o_bin_pairs,
    output logic [CNT_W-1:0]             o_column_pairs
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 2;
    localparam int WW   = (DW + 1 > 25) ? DW + 1 : 25;
    localparam int AW   = $clog2(MAX_ATOMS);
    localparam int HN   = MAX_BINS * MAX_COLUMNS;
    localparam int HAW  = $clog2(HN);
    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int ADW  = 3*C + TYPE_W;

    t_state n_state, r_state;

    // configuration
    logic [22:0] r_box;
    logic        r_periodic;
    logic [23:0] r_scale;
    logic [8:0]  r_bcount;
    logic [35:0] r_labels;

    // current item
    logic signed [C-1:0]  r_x, r_y, r_z;
    logic [TYPE_W-1:0]    r_type;
    logic [BINIDX_W-1:0]  r_bin_idx;
    logic [COLIDX_W-1:0]  r_col_idx;

    // atom store
    logic [ADW-1:0] r_atoms [MAX_ATOMS];
    logic [ADW-1:0] r_atom;
    logic [AW:0]    r_count;
    logic [AW-1:0]  r_k;

    // distance datapath
    logic signed [DW-1:0] r_dx, r_dy, r_dz;
    logic [2*DW-1:0]      r_sqx, r_sqy, r_sqz;
    logic [63:0]          r_v;
    logic [34:0]          r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [4:0]           r_step;
    logic [55:0]          r_prod;
    logic [LABEL_W-1:0]   r_lab_own;
    logic [HAW-1:0]       r_base;
    logic                 r_bin_ok;
    logic                 r_phase;

    // histogram and totals
    logic [CNT_W-1:0] r_hist [HN];
    logic [CNT_W-1:0] r_hdata;
    logic [CNT_W-1:0] r_tot [MAX_COLUMNS];
    logic [HAW:0]     r_clr;
    logic             r_rd_oor;

    // result register
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_bp;
    logic [CNT_W-1:0] r_out_cp;

    logic                 last_pair;
    logic                 clr_last;
    logic [LABEL_W-1:0]   lab_all;
    logic [LABEL_W-1:0]   cur_lab;
    logic                 cur_ok;
    logic [HAW-1:0]       h_raddr;
    logic                 h_we;
    logic [HAW-1:0]       h_waddr;
    logic [CNT_W-1:0]     h_wdata;
    logic                 out_free;
    logic [34:0]          rem_sh;
    logic [34:0]          trial;
    logic [27:0]          bin_val;
    logic [TYPE_W-1:0]    st_type;
    logic [3:0]           lab_pos;
    logic                 atoms_full;

    function automatic logic signed [DW-1:0] wrap_axis(
        input logic signed [DW-1:0] d,
        input logic [22:0]          box,
        input logic                 per
    );
        logic signed [WW-1:0] dd;
        logic signed [WW-1:0] tw;
        logic signed [WW-1:0] bb;
        dd = WW'(d);
        tw = dd <<< 1;
        bb = WW'({1'b0, box});
        if (per) begin
            if (tw > bb) dd = dd - bb;
            else if (tw < -bb) dd = dd + bb;
        end
        return DW'(dd);
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
        logic signed [DW-1:0] nd;
        nd = -d;
        return d[DW-1] ? DW'(nd) : DW'(d);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    assign o_init      = (r_state == ST_INIT);
    assign out_free    = !r_out_valid || i_m_tready;
    assign last_pair   = (({1'b0, r_k} + (AW+1)'(1)) == r_count);
    assign clr_last    = (r_clr == (HAW+1)'(HN - 1));
    assign atoms_full  = (r_count == (AW+1)'(MAX_ATOMS));
    assign lab_all     = r_labels[LABEL_W-1:0];
    assign st_type     = r_atom[ADW-1:3*C];
    assign lab_pos     = 4'(st_type) * 4'd3 + 4'(r_type);
    assign cur_lab     = r_phase ? r_lab_own : lab_all;
    assign cur_ok      = r_bin_ok && (cur_lab != '0)
                         && (5'(cur_lab) < 5'(MAX_COLUMNS));
    assign bin_val     = r_prod[55:28];
    assign rem_sh      = {r_rem[32:0], r_v[63:62]};
    assign trial       = 35'({r_root, 2'b01});

    // histogram port selection
    always_comb begin
        h_raddr = r_base + HAW'(cur_lab);
        if (r_state == ST_RD || r_state == ST_OUT || r_state == ST_IDLE) begin
            h_raddr = HAW'(r_bin_idx) * HAW'(MAX_COLUMNS) + HAW'(r_col_idx);
        end
        h_we    = 1'b0;
        h_waddr = r_base + HAW'(cur_lab);
        h_wdata = sat_inc(r_hdata);
        if (r_state == ST_INIT || r_state == ST_CLEAR) begin
            h_we    = 1'b1;
            h_waddr = HAW'(r_clr);
            h_wdata = '0;
        end else if (r_state == ST_HWR) begin
            h_we = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_INIT, ST_CLEAR: begin
                if (clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd)
                        CMD_ADD:   n_state = ST_BIN;
                        CMD_READ:  n_state = ST_RD;
                        CMD_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_IDLE;
                    endcase
                    // add: decide between pairing, storing or dropping
                    if (i_cmd == CMD_ADD) begin
                        if (atoms_full) n_state = ST_IDLE;
                        else if (r_count == '0) n_state = ST_STORE;
                        else n_state = ST_PAIR_RD;
                    end
                end
            end
            ST_PAIR_RD: n_state = ST_DIFF;
            ST_DIFF:    n_state = ST_SQ;
            ST_SQ:      n_state = ST_SUM;
            ST_SUM:     n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_step == 5'd31) n_state = ST_SCALE;
            end
            ST_SCALE:   n_state = ST_BIN;
            ST_BIN:     n_state = ST_HRD;
            ST_HRD: begin
                if (cur_ok) n_state = ST_HWR;
                else if (!r_phase) n_state = ST_HRD;
                else if (last_pair) n_state = ST_STORE;
                else n_state = ST_PAIR_RD;
            end
            ST_HWR: begin
                if (!r_phase) n_state = ST_HRD;
                else if (last_pair) n_state = ST_STORE;
                else n_state = ST_PAIR_RD;
            end
            ST_STORE:   n_state = ST_IDLE;
            ST_RD:      n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // control state, configuration, counts and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_box       <= RST_BOX_SIZE;
            r_periodic  <= RST_PERIODIC;
            r_scale     <= RST_BIN_SCALE;
            r_bcount    <= RST_BIN_COUNT;
            r_labels    <= RST_LABELS;
            for (int i = 0; i < MAX_COLUMNS; i++) r_tot[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BOX_SIZE:  r_box      <= i_cfg_data[22:0];
                    CFG_PERIODIC:  r_periodic <= i_cfg_data[0];
                    CFG_BIN_SCALE: r_scale    <= i_cfg_data[23:0];
                    CFG_BIN_COUNT: r_bcount   <= i_cfg_data[8:0];
                    CFG_LABELS:    r_labels   <= i_cfg_data;
                    default:       ;
                endcase
            end
            // clearing sweep
            if (r_state == ST_INIT || r_state == ST_CLEAR) r_clr <= r_clr + (HAW+1)'(1);
            else r_clr <= '0;
            if (r_state == ST_IDLE && i_valid && i_cmd == CMD_CLEAR) begin
                r_count <= '0;
                for (int i = 0; i < MAX_COLUMNS; i++) r_tot[i] <= '0;
            end
            if (r_state == ST_HWR) r_tot[CW'(cur_lab)] <= sat_inc(r_tot[CW'(cur_lab)]);
            if (r_state == ST_STORE) r_count <= r_count + (AW+1)'(1);
            // result register: drop on transfer, load when the read finishes
            if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;
            if (r_state == ST_OUT && out_free) r_out_valid <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_x       <= i_x;
            r_y       <= i_y;
            r_z       <= i_z;
            r_type    <= i_type;
            r_bin_idx <= i_bin;
            r_col_idx <= i_col;
            r_k       <= '0;
        end
        if (r_state == ST_DIFF) begin
            r_dx <= wrap_axis(DW'(r_x) - DW'($signed(r_atom[C-1:0])), r_box, r_periodic);
            r_dy <= wrap_axis(DW'(r_y) - DW'($signed(r_atom[2*C-1:C])), r_box, r_periodic);
            r_dz <= wrap_axis(DW'(r_z) - DW'($signed(r_atom[3*C-1:2*C])), r_box,
                              r_periodic);
            r_lab_own <= (st_type > 2'd2 || r_type > 2'd2) ? '0
                         : r_labels[{lab_pos, 2'b00} +: LABEL_W];
        end
        if (r_state == ST_SQ) begin
            r_sqx <= mag(r_dx) * mag(r_dx);
            r_sqy <= mag(r_dy) * mag(r_dy);
            r_sqz <= mag(r_dz) * mag(r_dz);
        end
        if (r_state == ST_SUM) begin
            r_v    <= 64'(r_sqx) + 64'(r_sqy) + 64'(r_sqz);
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end
        // one root bit per cycle
        if (r_state == ST_ROOT) begin
            r_v    <= {r_v[61:0], 2'b00};
            r_step <= r_step + 5'd1;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (r_state == ST_SCALE) r_prod <= 56'(r_root) * 56'(r_scale);
        if (r_state == ST_BIN) begin
            r_bin_ok <= (bin_val < 28'(r_bcount)) && (bin_val < 28'(MAX_BINS));
            r_base   <= HAW'(bin_val) * HAW'(MAX_COLUMNS);
            r_phase  <= 1'b0;
        end
        if ((r_state == ST_HRD && !cur_ok && !r_phase) || (r_state == ST_HWR && !r_phase))
            r_phase <= 1'b1;
        if ((r_state == ST_HRD && !cur_ok && r_phase) || (r_state == ST_HWR && r_phase))
            r_k <= r_k + AW'(1);
        if (r_state == ST_RD) begin
            r_rd_oor <= ({24'd0, r_bin_idx} >= 32'(MAX_BINS))
                        || ({29'd0, r_col_idx} >= 32'(MAX_COLUMNS));
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_bp <= r_rd_oor ? '0 : r_hdata;
            r_out_cp <= r_rd_oor ? '0 : r_tot[CW'(r_col_idx)];
        end
    end

    // atom store memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_STORE) r_atoms[AW'(r_count)] <= {r_type, r_z, r_y, r_x};
        r_atom <= r_atoms[r_k];
    end

    // histogram memory
    always_ff @(posedge i_clk) begin
        if (h_we) r_hist[h_waddr] <= h_wdata;
        r_hdata <= r_hist[h_raddr];
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_bin_pairs    = r_out_bp;
    assign o_column_pairs = r_out_cp;

endmodule

@@ tb/sv/pair_distance_histogram_unit_test.sv @@
// Self-checking testbench of the pair distance histogram unit: stream stimulus and predictor.
`timescale 1ns / 100ps

module pair_distance_histogram_unit_test;
    import pdh_pkg::*;

    localparam int ATOM_CAP  = 1024;
    localparam int BIN_CAP   = 256;
    localparam int COL_CAP   = 8;
    localparam int LIMIT_CYC = 3000000;

    // Packed as on the result bus, highest field first
    typedef struct packed {
        logic [CNT_W-1:0] column_pairs;
        logic [CNT_W-1:0] bin_pairs;
    } t_bin_read;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    // pos_x, pos_y, pos_z, atom_type, bin_index, column, zero fill
    logic [87:0]             i_s_tdata;
    // command
    logic [1:0]              i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    // bin_pairs, column_pairs
    logic [2*CNT_W-1:0]      o_m_tdata;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    pair_distance_histogram_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state
    longint                  atom_x [ATOM_CAP];
    longint                  atom_y [ATOM_CAP];
    longint                  atom_z [ATOM_CAP];
    logic [1:0]              atom_kind [ATOM_CAP];
    int                      atoms_held;
    int unsigned             hist_cell [BIN_CAP][COL_CAP];
    int unsigned             col_total [COL_CAP];
    longint                  box_len;
    logic                    wrap_on;
    longint unsigned         bins_per_unit;
    int unsigned             bins_used;
    logic [35:0]             pair_labels;

    t_bin_read               pending_reads [$];
    int                      fail_count;
    int                      idle_pct;
    int                      stall_pct;
    int unsigned             cycle_count = 0;

    // Squared magnitude of one axis difference after the optional wrap
    function automatic longint unsigned axis_sq(longint d);
        if (wrap_on) begin
            if (2 * d > box_len) d = d - box_len;
            else if (2 * d < -box_len) d = d + box_len;
        end
        if (d < 0) d = -d;
        return longint'(d) * d;
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int unsigned pair_column(int unsigned first, int unsigned second);
        if (first > 2 || second > 2) return 0;
        return pair_labels[4 * (first * 3 + second) +: 4];
    endfunction

    function automatic void count_pair(int unsigned bin, int unsigned col);
        if (col == 0 || col >= COL_CAP) return;
        if (hist_cell[bin][col] < COUNT_MAX) hist_cell[bin][col]++;
        if (col_total[col] < COUNT_MAX) col_total[col]++;
    endfunction

    function automatic void wipe_histogram();
        atoms_held = 0;
        foreach (hist_cell[b, c]) hist_cell[b][c] = 0;
        foreach (col_total[c]) col_total[c] = 0;
    endfunction

    // Pair a new atom with every stored one, then store it
    function automatic void add_atom(logic signed [23:0] x, logic signed [23:0] y,
                                     logic signed [23:0] z, logic [1:0] kind);
        longint unsigned dist_sq;
        longint unsigned bin;
        int unsigned     all_col;
        if (atoms_held >= ATOM_CAP) return;
        all_col = pair_column(0, 0);
        for (int k = 0; k < atoms_held; k++) begin
            dist_sq = axis_sq(longint'(x) - atom_x[k]) + axis_sq(longint'(y) - atom_y[k])
                    + axis_sq(longint'(z) - atom_z[k]);
            bin = (int_root(dist_sq) * bins_per_unit) >> 28;
            if (bin >= bins_used || bin >= BIN_CAP) continue;
            count_pair(bin, all_col);
            count_pair(bin, pair_column(atom_kind[k], kind));
        end
        atom_x[atoms_held] = x;
        atom_y[atoms_held] = y;
        atom_z[atoms_held] = z;
        atom_kind[atoms_held] = kind;
        atoms_held++;
    endfunction

    // Send one command; predict once the transfer is taken
    task automatic send_item(t_cmd cmd, logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z, logic [1:0] kind,
                             logic [7:0] bin, logic [2:0] col);
        t_bin_read rd;
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {3'b0, col, bin, kind, z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        case (cmd)
            CMD_ADD:   add_atom(x, y, z, kind);
            CMD_READ: begin
                rd.bin_pairs    = hist_cell[bin][col];
                rd.column_pairs = col_total[col];
                pending_reads.push_back(rd);
            end
            CMD_CLEAR: wipe_histogram();
            default: ;
        endcase
    endtask

    task automatic send_read(int unsigned bin, int unsigned col);
        send_item(CMD_READ, 0, 0, 0, 0, bin, col);
    endtask

    // Wait until the engine has finished everything queued
    task automatic drain();
        send_read(0, 0);
        i_s_tvalid <= 1'b0;
        wait (pending_reads.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [35:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BOX_SIZE:  box_len = value[22:0];
            CFG_PERIODIC:  wrap_on = value[0];
            CFG_BIN_SCALE: bins_per_unit = value[23:0];
            CFG_BIN_COUNT: bins_used = value[8:0];
            CFG_LABELS:    pair_labels = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [22:0] box, logic per, logic [23:0] scale,
                              logic [8:0] nbins, logic [35:0] labels);
        write_reg(CFG_BOX_SIZE, box);
        write_reg(CFG_PERIODIC, per);
        write_reg(CFG_BIN_SCALE, scale);
        write_reg(CFG_BIN_COUNT, nbins);
        write_reg(CFG_LABELS, labels);
    endtask

    function automatic logic signed [23:0] pick_coord(int unsigned span);
        if ($urandom_range(9) == 0) return $urandom();
        return $signed($urandom_range(2 * span)) - $signed(span);
    endfunction

    // One clear, a small set of atoms, then reads biased to low bins
    task automatic play_set(int unsigned n_atoms, int unsigned n_reads, int unsigned span);
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        repeat (n_atoms)
            send_item(CMD_ADD, pick_coord(span), pick_coord(span), pick_coord(span),
                      $urandom_range(2), $urandom(), $urandom());
        repeat (n_reads)
            send_read(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(31),
                      $urandom_range(7));
    endtask

    task automatic test_reset_config();
        send_item(CMD_ADD, 0, 0, 0, 0, 0, 0);
        send_item(CMD_ADD, 24'sd100, 0, 0, 0, 0, 0);
        send_read(0, 0);
        drain();
    endtask

    task automatic test_directed();
        set_config(23'd4096, 1'b1, 24'd524288, 9'd256, 36'h9_F_8_7_6_5_4_3_2);
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_item(CMD_ADD, 0, 0, 0, 0, 0, 0);
        send_item(CMD_ADD, 24'sd3000, 0, 0, 1, 0, 0);
        send_item(CMD_ADD, 24'sd8388607, -24'sd8388608, 24'sd8388607, 2, 8'hFF, 3'h7);
        send_item(CMD_ADD, -24'sd8388608, 24'sd8388607, -24'sd8388608, 3, 0, 0);
        send_item(CMD_ADD, 24'sd2048, 24'sd2048, 24'sd2048, 0, 0, 0);
        send_item(CMD_NOP, 24'sd5, 24'sd5, 24'sd5, 1, 8'd3, 3'd2);
        send_item(CMD_ADD, 24'sd1000, -24'sd1000, 24'sd500, 2, 0, 0);
        for (int c = 0; c < COL_CAP; c++) send_read(c * 3, c);
        send_read(255, 7);
        send_read(0, 2);
        drain();
        // Extreme settings: tiny box, no wrap, zero and full scale, single bin
        set_config(23'd1, 1'b0, 24'd0, 9'd1, 36'hFFFFFFFFF);
        play_set(4, 3, 4096);
        drain();
        set_config(23'd8388607, 1'b1, 24'd16777215, 9'd256, 36'h1_2_3_4_5_6_7_8_2);
        play_set(5, 4, 8388607);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int sets);
        idle_pct  = idle;
        stall_pct = stall;
        for (int s = 0; s < sets; s++) begin
            if (s % 4 == 0) begin
                drain();
                set_config($urandom_range(16384, 1024), $urandom_range(1),
                           $urandom_range(1 << 21, 1 << 16),
                           ($urandom_range(4) == 0) ? $urandom_range(256, 1) : 9'd256,
                           {$urandom(), $urandom()});
            end
            play_set($urandom_range(12, 2), $urandom_range(8, 3), box_len);
        end
    endtask

    // Receiver ready, stalled at random
    always @(posedge i_clk) i_m_tready <= ($urandom_range(99) >= stall_pct);

    // Check every result transfer against the oldest expected read
    always @(posedge i_clk) begin
        t_bin_read want;
        t_bin_read got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (pending_reads.size() == 0) begin
                $error("result with nothing expected: %h", o_m_tdata);
                fail_count++;
            end else begin
                want = pending_reads.pop_front();
                if (got.bin_pairs != want.bin_pairs) begin
                    $error("bin_pairs expected %0d actual %0d", want.bin_pairs,
                           got.bin_pairs);
                    fail_count++;
                end
                if (got.column_pairs != want.column_pairs) begin
                    $error("column_pairs expected %0d actual %0d", want.column_pairs,
                           got.column_pairs);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYC) begin
            $display("pair_distance_histogram_unit verification failed");
            $finish;
        end
    end

    initial begin
        fail_count    = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        box_len       = RST_BOX_SIZE;
        wrap_on       = RST_PERIODIC;
        bins_per_unit = RST_BIN_SCALE;
        bins_used     = RST_BIN_COUNT;
        pair_labels   = RST_LABELS;
        wipe_histogram();
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= CMD_NOP;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_BOX_SIZE;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_directed();
        test_random_phase(0, 0, 10);
        test_random_phase(76, 0, 10);
        test_random_phase(0, 76, 10);
        test_random_phase(9, 9, 10);

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending_reads.size() == 0)
            $display("pair_distance_histogram_unit verification clean");
        else
            $display("pair_distance_histogram_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pdh_pkg.sv
hw/rtl/pdh_front.sv
hw/rtl/pdh_back.sv
hw/rtl/pair_distance_histogram_unit.sv
tb/sv/pair_distance_histogram_unit_test.sv
